// ===== rtl/core/mnd_pkg.sv =====
// Package for the music note decoder: widths, character codes, error codes
// and the base pitch table. No dependencies.
package mnd_pkg;

    localparam int CHAR_W  = 8;
    localparam int WHOLE_W = 18;
    localparam int TONE_W  = 14;
    localparam int SOUND_W = 19;
    localparam int SIL_W   = 16;
    localparam int ERR_W   = 3;
    localparam int PITCH_W = 12;
    localparam int OCT_W   = 4;
    localparam int FRAC_W  = 7;
    localparam int SEMI_W  = 4;

    // shared divider: dividend holds the whole note, divisor the fraction; the
    // dividend register also carries pitch << 9 at most for the tone scaling
    localparam int DIV_W   = 21;
    localparam int DVSR_W  = 7;
    localparam int CNT_W   = $clog2(DIV_W);

    // x / 100 as (x * TONE_RECIP) >> TONE_SHIFT, exact for x below 2**21
    localparam int RECIP_W    = 22;
    localparam int PROD_W     = DIV_W + RECIP_W;
    localparam int TONE_SHIFT = 28;
    localparam logic [RECIP_W-1:0] TONE_RECIP = 22'd2684355;

    localparam logic [WHOLE_W-1:0] WHOLE_RESET = 18'd2000;

    localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_ACC   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_NO_NAME   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NO_OCTAVE = 3'd3;
    localparam logic [ERR_W-1:0] ERR_NO_SLASH  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_NO_FRAC   = 3'd5;
    localparam logic [ERR_W-1:0] ERR_ZERO_FRAC = 3'd6;

    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h42;
    localparam logic [CHAR_W-1:0] CH_C     = 8'h43;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
    localparam logic [CHAR_W-1:0] CH_E     = 8'h45;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h46;
    localparam logic [CHAR_W-1:0] CH_G     = 8'h47;
    localparam logic [CHAR_W-1:0] CH_R     = 8'h52;
    localparam logic [CHAR_W-1:0] CH_SHARP = 8'h23;
    localparam logic [CHAR_W-1:0] CH_FLAT  = 8'h62;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_TIE   = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_2     = 8'h32;
    localparam logic [CHAR_W-1:0] CH_8     = 8'h38;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;

    // semitone 0 is C, in hundredths of a hertz at the lowest octave
    function automatic logic [PITCH_W-1:0] pitch_of(input logic [SEMI_W-1:0] semi);
        logic [PITCH_W-1:0] p;
        case (semi)
            4'd0:    p = 12'd1635;
            4'd1:    p = 12'd1732;
            4'd2:    p = 12'd1835;
            4'd3:    p = 12'd1945;
            4'd4:    p = 12'd2060;
            4'd5:    p = 12'd2183;
            4'd6:    p = 12'd2312;
            4'd7:    p = 12'd2450;
            4'd8:    p = 12'd2596;
            4'd9:    p = 12'd2750;
            4'd10:   p = 12'd2914;
            4'd11:   p = 12'd3087;
            default: p = 12'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/mnd_ifs.sv =====
// Handshake channels of the music note decoder: character input, result
// output and the whole-note length write port. Uses mnd_pkg for widths.
interface mnd_char_if;
    logic                          valid;
    logic                          ready;
    logic [mnd_pkg::CHAR_W-1:0]    note_char;
    logic                          last_char;
    modport source (output valid, output note_char, output last_char, input ready);
    modport sink   (input valid, input note_char, input last_char, output ready);
endinterface

interface mnd_result_if;
    logic                          valid;
    logic                          ready;
    logic [mnd_pkg::TONE_W-1:0]    tone_hz;
    logic [mnd_pkg::SOUND_W-1:0]   sound_ms;
    logic [mnd_pkg::SIL_W-1:0]     silence_ms;
    logic                          tied;
    logic [mnd_pkg::ERR_W-1:0]     error_code;
    modport source (output valid, output tone_hz, output sound_ms, output silence_ms,
                    output tied, output error_code, input ready);
    modport sink   (input valid, input tone_hz, input sound_ms, input silence_ms,
                    input tied, input error_code, output ready);
endinterface

interface mnd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mnd_pkg::WHOLE_W-1:0]   whole_note_ms;
    modport source (output valid, output whole_note_ms, input ready);
    modport sink   (input valid, input whole_note_ms, output ready);
endinterface

// ===== rtl/core/music_note_decoder_unit.sv =====
// Music note decoder top level: character parser, sequencer and one shared
// restoring divider. Depends on mnd_pkg and the channels in mnd_ifs.sv.
// A character that does not end a note is taken every cycle. The final one starts the
// sequencer: tone multiply and 21 divider steps for a pitched note, the divider steps
// alone for a rest, neither on an error; input ready again once the result is loaded,
// later while the previous result is still held. Sync active-low reset: whole note 2000 ms.
module music_note_decoder_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mnd_char_if.sink              i_char,
    mnd_cfg_if.sink               i_cfg,
    mnd_result_if.source          o_result
);

    typedef enum logic [3:0] {
        PH_NAME, PH_ACC, PH_OCT, PH_SLASH, PH_FRAC1, PH_FRAC2, PH_DOT, PH_TIE, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE, SQ_TONE, SQ_DIV_LEN, SQ_FINISH
    } t_seq;

    // parse state
    t_phase                          r_phase, n_phase, p_phase;
    logic [mnd_pkg::SEMI_W-1:0]      r_semi, n_semi, p_semi;
    logic [mnd_pkg::PITCH_W-1:0]     r_pitch, n_pitch, p_pitch;
    logic [mnd_pkg::OCT_W-1:0]       r_oct, n_oct, p_oct;
    logic [mnd_pkg::FRAC_W-1:0]      r_frac, n_frac, p_frac;
    logic                            r_dot, n_dot, p_dot;
    logic                            r_tie, n_tie, p_tie;
    logic [mnd_pkg::ERR_W-1:0]       r_err, n_err, p_err, fin_err;

    // sequencer and divider
    t_seq                            r_state, n_state;
    logic [mnd_pkg::WHOLE_W-1:0]     r_whole, n_whole;
    logic [mnd_pkg::DVSR_W-1:0]      r_rem, n_rem, step_rem;
    logic [mnd_pkg::DIV_W-1:0]       r_quo, n_quo, step_quo;
    logic [mnd_pkg::DVSR_W-1:0]      r_dvsr, n_dvsr;
    logic [mnd_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [mnd_pkg::TONE_W-1:0]      r_tone, n_tone;
    logic [mnd_pkg::SOUND_W-1:0]     r_len, n_len;
    logic [mnd_pkg::DVSR_W:0]        trial, trial_diff;
    logic                            trial_ge;
    logic [mnd_pkg::PROD_W-1:0]      tone_prod;

    // output register
    logic                            r_out_valid, n_out_valid;
    logic [mnd_pkg::TONE_W-1:0]      r_o_tone, n_o_tone;
    logic [mnd_pkg::SOUND_W-1:0]     r_o_snd, n_o_snd;
    logic [mnd_pkg::SIL_W-1:0]       r_o_sil, n_o_sil;
    logic                            r_o_tied, n_o_tied;
    logic [mnd_pkg::ERR_W-1:0]       r_o_err, n_o_err;

    logic                            in_take, out_take, out_free;
    logic [mnd_pkg::CHAR_W-1:0]      ch;
    logic                            go_oct, go_dot, go_tie, is_dig;
    logic [mnd_pkg::SOUND_W-1:0]     len_eighth, len_sound;
    logic [mnd_pkg::OCT_W-1:0]       shift_amt;

    assign ch        = i_char.note_char;
    assign in_take   = i_char.valid && i_char.ready;
    assign out_take  = r_out_valid && o_result.ready;
    assign out_free  = !r_out_valid || o_result.ready;

    assign i_char.ready        = (r_state == SQ_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_result.valid      = r_out_valid;
    assign o_result.tone_hz    = r_o_tone;
    assign o_result.sound_ms   = r_o_snd;
    assign o_result.silence_ms = r_o_sil;
    assign o_result.tied       = r_o_tied;
    assign o_result.error_code = r_o_err;

    // character parser: next parse state for the character on the input
    always_comb begin
        p_phase = r_phase;
        p_semi  = r_semi;
        p_pitch = r_pitch;
        p_oct   = r_oct;
        p_frac  = r_frac;
        p_dot   = r_dot;
        p_tie   = r_tie;
        p_err   = r_err;
        go_oct  = 1'b0;
        go_dot  = 1'b0;
        go_tie  = 1'b0;
        is_dig  = (ch >= mnd_pkg::CH_0) && (ch <= mnd_pkg::CH_9);
        if (r_err == mnd_pkg::ERR_OK) begin
            case (r_phase)
                PH_NAME: begin
                    p_phase = PH_ACC;
                    case (ch)
                        mnd_pkg::CH_C: p_semi = 4'd0;
                        mnd_pkg::CH_D: p_semi = 4'd2;
                        mnd_pkg::CH_E: p_semi = 4'd4;
                        mnd_pkg::CH_F: p_semi = 4'd5;
                        mnd_pkg::CH_G: p_semi = 4'd7;
                        mnd_pkg::CH_A: p_semi = 4'd9;
                        mnd_pkg::CH_B: p_semi = 4'd11;
                        mnd_pkg::CH_R: p_phase = PH_SLASH;
                        default: begin
                            p_phase = PH_NAME;
                            p_err   = mnd_pkg::ERR_NO_NAME;
                        end
                    endcase
                    if (p_phase == PH_ACC) begin
                        p_pitch = mnd_pkg::pitch_of(p_semi);
                    end else if (p_phase == PH_SLASH) begin
                        p_pitch = '0;
                    end
                end
                PH_ACC: begin
                    p_phase = PH_OCT;
                    if (ch == mnd_pkg::CH_SHARP) begin
                        if (r_semi == 4'd4 || r_semi == 4'd11) begin
                            p_err = mnd_pkg::ERR_BAD_ACC;
                        end else begin
                            p_semi = r_semi + 4'd1;
                        end
                    end else if (ch == mnd_pkg::CH_FLAT) begin
                        if (r_semi == 4'd0 || r_semi == 4'd5) begin
                            p_err = mnd_pkg::ERR_BAD_ACC;
                        end else begin
                            p_semi = r_semi - 4'd1;
                        end
                    end else begin
                        go_oct = 1'b1;
                    end
                    if (p_err != mnd_pkg::ERR_OK) begin
                        p_phase = PH_ACC;
                    end
                    p_pitch = mnd_pkg::pitch_of(p_semi);
                end
                PH_OCT:   go_oct = 1'b1;
                PH_SLASH: begin
                    if (ch == mnd_pkg::CH_SLASH) begin
                        p_phase = PH_FRAC1;
                    end else begin
                        p_err = mnd_pkg::ERR_NO_SLASH;
                    end
                end
                PH_FRAC1: begin
                    if (is_dig) begin
                        p_frac  = mnd_pkg::FRAC_W'(ch[3:0]);
                        p_phase = PH_FRAC2;
                    end else begin
                        p_err = mnd_pkg::ERR_NO_FRAC;
                    end
                end
                PH_FRAC2: begin
                    if (is_dig) begin
                        p_frac  = mnd_pkg::FRAC_W'(r_frac * 7'd10 + mnd_pkg::FRAC_W'(ch[3:0]));
                        p_phase = PH_DOT;
                    end else begin
                        go_dot = 1'b1;
                    end
                end
                PH_DOT:  go_dot = 1'b1;
                PH_TIE:  go_tie = 1'b1;
                PH_DONE: ;
                default: ;
            endcase
            if (go_oct) begin
                if (ch >= mnd_pkg::CH_2 && ch <= mnd_pkg::CH_8) begin
                    p_oct   = ch[3:0];
                    p_phase = PH_SLASH;
                end else begin
                    p_phase = PH_OCT;
                    p_err   = mnd_pkg::ERR_NO_OCTAVE;
                end
            end
            if (go_dot) begin
                if (ch == mnd_pkg::CH_DOT) begin
                    p_dot   = 1'b1;
                    p_phase = PH_TIE;
                end else begin
                    go_tie = 1'b1;
                end
            end
            if (go_tie) begin
                if (ch == mnd_pkg::CH_TIE) begin
                    p_tie = 1'b1;
                end
                p_phase = PH_DONE;
            end
        end

        // end-of-note checks on the state the final character leaves
        fin_err = p_err;
        if (p_err == mnd_pkg::ERR_OK) begin
            case (p_phase)
                PH_NAME:         fin_err = mnd_pkg::ERR_NO_NAME;
                PH_ACC, PH_OCT:  fin_err = mnd_pkg::ERR_NO_OCTAVE;
                PH_SLASH:        fin_err = mnd_pkg::ERR_NO_SLASH;
                PH_FRAC1:        fin_err = mnd_pkg::ERR_NO_FRAC;
                default: begin
                    if (p_frac == '0) begin
                        fin_err = mnd_pkg::ERR_ZERO_FRAC;
                    end
                end
            endcase
        end
    end

    // one restoring step of the shared divider
    always_comb begin
        trial      = {r_rem, r_quo[mnd_pkg::DIV_W-1]};
        trial_ge   = trial >= {1'b0, r_dvsr};
        trial_diff = trial - {1'b0, r_dvsr};
        step_rem   = trial_ge ? trial_diff[mnd_pkg::DVSR_W-1:0] : trial[mnd_pkg::DVSR_W-1:0];
        step_quo   = {r_quo[mnd_pkg::DIV_W-2:0], trial_ge};
    end

    // scaled pitch / 100 by reciprocal multiply
    assign tone_prod  = mnd_pkg::PROD_W'(r_quo) * mnd_pkg::PROD_W'(mnd_pkg::TONE_RECIP);

    assign shift_amt  = p_oct + 4'd1;
    assign len_eighth = r_len >> 3;
    assign len_sound  = r_len - len_eighth - mnd_pkg::SOUND_W'(|r_len[2:0]);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_semi      = r_semi;
        n_pitch     = r_pitch;
        n_oct       = r_oct;
        n_frac      = r_frac;
        n_dot       = r_dot;
        n_tie       = r_tie;
        n_err       = r_err;
        n_whole     = r_whole;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dvsr      = r_dvsr;
        n_cnt       = r_cnt;
        n_tone      = r_tone;
        n_len       = r_len;
        n_out_valid = r_out_valid && !out_take;
        n_o_tone    = r_o_tone;
        n_o_snd     = r_o_snd;
        n_o_sil     = r_o_sil;
        n_o_tied    = r_o_tied;
        n_o_err     = r_o_err;

        if (i_cfg.valid && i_cfg.ready) begin
            n_whole = i_cfg.whole_note_ms;
        end

        case (r_state)
            SQ_IDLE: begin
                if (in_take) begin
                    n_phase = p_phase;
                    n_semi  = p_semi;
                    n_pitch = p_pitch;
                    n_oct   = p_oct;
                    n_frac  = p_frac;
                    n_dot   = p_dot;
                    n_tie   = p_tie;
                    n_err   = p_err;
                    if (i_char.last_char) begin
                        n_err  = fin_err;
                        n_rem  = '0;
                        n_cnt  = mnd_pkg::CNT_W'(mnd_pkg::DIV_W - 1);
                        n_tone = '0;
                        n_len  = '0;
                        if (fin_err != mnd_pkg::ERR_OK) begin
                            n_state = SQ_FINISH;
                        end else if (p_pitch != '0) begin
                            n_quo   = mnd_pkg::DIV_W'(p_pitch) << shift_amt;
                            n_state = SQ_TONE;
                        end else begin
                            n_quo   = mnd_pkg::DIV_W'(r_whole);
                            n_dvsr  = p_frac;
                            n_state = SQ_DIV_LEN;
                        end
                    end
                end
            end
            SQ_TONE: begin
                n_tone  = tone_prod[mnd_pkg::TONE_SHIFT +: mnd_pkg::TONE_W];
                n_rem   = '0;
                n_quo   = mnd_pkg::DIV_W'(r_whole);
                n_dvsr  = r_frac;
                n_cnt   = mnd_pkg::CNT_W'(mnd_pkg::DIV_W - 1);
                n_state = SQ_DIV_LEN;
            end
            SQ_DIV_LEN: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt - mnd_pkg::CNT_W'(1);
                if (r_cnt == '0) begin
                    // dotted: 3*len/2 truncated is len + len/2
                    n_len = mnd_pkg::SOUND_W'(step_quo[mnd_pkg::WHOLE_W-1:0])
                          + (r_dot ? mnd_pkg::SOUND_W'(step_quo[mnd_pkg::WHOLE_W-1:1])
                                   : '0);
                    n_state = SQ_FINISH;
                end
            end
            SQ_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_err     = r_err;
                    if (r_err != mnd_pkg::ERR_OK) begin
                        n_o_tone = '0;
                        n_o_snd  = '0;
                        n_o_sil  = '0;
                        n_o_tied = 1'b0;
                    end else begin
                        n_o_tone = r_tone;
                        n_o_tied = r_tie;
                        n_o_snd  = r_tie ? r_len : len_sound;
                        n_o_sil  = r_tie ? '0 : len_eighth[mnd_pkg::SIL_W-1:0];
                    end
                    n_phase = PH_NAME;
                    n_semi  = '0;
                    n_pitch = '0;
                    n_oct   = '0;
                    n_frac  = '0;
                    n_dot   = 1'b0;
                    n_tie   = 1'b0;
                    n_err   = mnd_pkg::ERR_OK;
                    n_state = SQ_IDLE;
                end
            end
            default: n_state = SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SQ_IDLE;
            r_phase     <= PH_NAME;
            r_semi      <= '0;
            r_pitch     <= '0;
            r_oct       <= '0;
            r_frac      <= '0;
            r_dot       <= 1'b0;
            r_tie       <= 1'b0;
            r_err       <= mnd_pkg::ERR_OK;
            r_whole     <= mnd_pkg::WHOLE_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_semi      <= n_semi;
            r_pitch     <= n_pitch;
            r_oct       <= n_oct;
            r_frac      <= n_frac;
            r_dot       <= n_dot;
            r_tie       <= n_tie;
            r_err       <= n_err;
            r_whole     <= n_whole;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_dvsr   <= n_dvsr;
        r_tone   <= n_tone;
        r_len    <= n_len;
        r_o_tone <= n_o_tone;
        r_o_snd  <= n_o_snd;
        r_o_sil  <= n_o_sil;
        r_o_tied <= n_o_tied;
        r_o_err  <= n_o_err;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for music_note_decoder_unit: drives note text one character per item,
// predicts each note result and checks it. Needs mnd_pkg and the channels in mnd_ifs.sv.
module tb;

    localparam int RESULT_SLACK = 60;      // settling wait after the last result is back
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_CHARS  = 270;

    typedef enum logic [3:0] {
        SEEK_NAME, SEEK_ACC, SEEK_OCT, SEEK_SLASH, SEEK_FRAC1,
        SEEK_FRAC2, SEEK_DOT, SEEK_TIE, SEEK_END
    } t_scan_phase;

    typedef struct packed {
        logic [mnd_pkg::TONE_W-1:0]  tone_hz;
        logic [mnd_pkg::SOUND_W-1:0] sound_ms;
        logic [mnd_pkg::SIL_W-1:0]   silence_ms;
        logic                        tied;
        logic [mnd_pkg::ERR_W-1:0]   error_code;
    } t_note_result;

    typedef logic [mnd_pkg::CHAR_W-1:0] t_note_text[$];

    class note_scoreboard;
        t_note_result                due_q[$];
        logic [mnd_pkg::WHOLE_W-1:0] whole_ms;
        int unsigned                 pitch_centi[12];
        t_scan_phase                 phase;
        int unsigned                 semi;
        logic [mnd_pkg::PITCH_W-1:0] pitch;
        logic [mnd_pkg::OCT_W-1:0]   octave;
        logic [mnd_pkg::FRAC_W-1:0]  frac;
        bit                          dotted;
        bit                          tie;
        logic [mnd_pkg::ERR_W-1:0]   err;
        int unsigned                 fails;

        function new();
            pitch_centi = '{1635, 1732, 1835, 1945, 2060, 2183,
                            2312, 2450, 2596, 2750, 2914, 3087};
            whole_ms = mnd_pkg::WHOLE_RESET;
            fails = 0;
            clear_note();
        endfunction

        function void clear_note();
            phase = SEEK_NAME;
            semi = 0;
            pitch = '0;
            octave = '0;
            frac = '0;
            dotted = 0;
            tie = 0;
            err = mnd_pkg::ERR_OK;
        endfunction

        function void set_whole(logic [mnd_pkg::WHOLE_W-1:0] v);
            whole_ms = v;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // optional fields that are absent hand the character on to the next field
        function void scan_char(logic [mnd_pkg::CHAR_W-1:0] c);
            bit again;
            again = 1;
            while (again) begin
                again = 0;
                case (phase)
                    SEEK_NAME: begin
                        case (c)
                            mnd_pkg::CH_C: semi = 0;
                            mnd_pkg::CH_D: semi = 2;
                            mnd_pkg::CH_E: semi = 4;
                            mnd_pkg::CH_F: semi = 5;
                            mnd_pkg::CH_G: semi = 7;
                            mnd_pkg::CH_A: semi = 9;
                            mnd_pkg::CH_B: semi = 11;
                            mnd_pkg::CH_R: begin
                                pitch = '0;
                                phase = SEEK_SLASH;
                                return;
                            end
                            default: begin
                                err = mnd_pkg::ERR_NO_NAME;
                                return;
                            end
                        endcase
                        pitch = mnd_pkg::PITCH_W'(pitch_centi[semi]);
                        phase = SEEK_ACC;
                    end
                    SEEK_ACC: begin
                        if (c == mnd_pkg::CH_SHARP) begin
                            if (semi == 4 || semi == 11) begin
                                err = mnd_pkg::ERR_BAD_ACC;
                                return;
                            end
                            semi = semi + 1;
                            pitch = mnd_pkg::PITCH_W'(pitch_centi[semi % 12]);
                        end else if (c == mnd_pkg::CH_FLAT) begin
                            if (semi == 0 || semi == 5) begin
                                err = mnd_pkg::ERR_BAD_ACC;
                                return;
                            end
                            semi = semi - 1;
                            pitch = mnd_pkg::PITCH_W'(pitch_centi[semi % 12]);
                        end else begin
                            again = 1;
                        end
                        phase = SEEK_OCT;
                    end
                    SEEK_OCT: begin
                        if (c >= mnd_pkg::CH_2 && c <= mnd_pkg::CH_8) begin
                            octave = mnd_pkg::OCT_W'(c - mnd_pkg::CH_0);
                            phase = SEEK_SLASH;
                        end else begin
                            err = mnd_pkg::ERR_NO_OCTAVE;
                        end
                    end
                    SEEK_SLASH: begin
                        if (c == mnd_pkg::CH_SLASH) phase = SEEK_FRAC1;
                        else err = mnd_pkg::ERR_NO_SLASH;
                    end
                    SEEK_FRAC1: begin
                        if (c >= mnd_pkg::CH_0 && c <= mnd_pkg::CH_9) begin
                            frac = mnd_pkg::FRAC_W'(c - mnd_pkg::CH_0);
                            phase = SEEK_FRAC2;
                        end else begin
                            err = mnd_pkg::ERR_NO_FRAC;
                        end
                    end
                    SEEK_FRAC2: begin
                        if (c >= mnd_pkg::CH_0 && c <= mnd_pkg::CH_9)
                            frac = mnd_pkg::FRAC_W'(frac * 10 + (c - mnd_pkg::CH_0));
                        else again = 1;
                        phase = SEEK_DOT;
                    end
                    SEEK_DOT: begin
                        if (c == mnd_pkg::CH_DOT) dotted = 1;
                        else again = 1;
                        phase = SEEK_TIE;
                    end
                    SEEK_TIE: begin
                        if (c == mnd_pkg::CH_TIE) tie = 1;
                        phase = SEEK_END;
                    end
                    default: ;
                endcase
            end
        endfunction

        function void accept_char(logic [mnd_pkg::CHAR_W-1:0] c, logic last);
            t_note_result want;
            int unsigned  len;
            int unsigned  tone;
            int unsigned  snd;
            int unsigned  sil;
            if (err == mnd_pkg::ERR_OK) scan_char(c);
            if (!last) return;
            if (err == mnd_pkg::ERR_OK) begin
                if (phase == SEEK_NAME) err = mnd_pkg::ERR_NO_NAME;
                else if (phase == SEEK_ACC || phase == SEEK_OCT) err = mnd_pkg::ERR_NO_OCTAVE;
                else if (phase == SEEK_SLASH) err = mnd_pkg::ERR_NO_SLASH;
                else if (phase == SEEK_FRAC1) err = mnd_pkg::ERR_NO_FRAC;
                else if (frac == 0) err = mnd_pkg::ERR_ZERO_FRAC;
            end
            tone = 0;
            snd = 0;
            sil = 0;
            want.tied = 1'b0;
            if (err == mnd_pkg::ERR_OK) begin
                if (pitch != 0) tone = (32'(pitch) * (32'd2 << octave)) / 100;
                len = 32'(whole_ms) / 32'(frac);
                if (dotted) len = (3 * len) / 2;
                if (tie) begin
                    snd = len;
                    want.tied = 1'b1;
                end else begin
                    snd = (7 * len) / 8;
                    sil = len / 8;
                end
            end
            want.tone_hz    = mnd_pkg::TONE_W'(tone);
            want.sound_ms   = mnd_pkg::SOUND_W'(snd);
            want.silence_ms = mnd_pkg::SIL_W'(sil);
            want.error_code = err;
            due_q.push_back(want);
            clear_note();
        endfunction

        function void check_result(t_note_result got);
            t_note_result want;
            if (due_q.size() == 0) begin
                $error("result with none pending: tone_hz %0d error_code %0d",
                       got.tone_hz, got.error_code);
                fails++;
                return;
            end
            want = due_q.pop_front();
            if (got.tone_hz !== want.tone_hz) begin
                $error("tone_hz: expected %0d, got %0d", want.tone_hz, got.tone_hz);
                fails++;
            end
            if (got.sound_ms !== want.sound_ms) begin
                $error("sound_ms: expected %0d, got %0d", want.sound_ms, got.sound_ms);
                fails++;
            end
            if (got.silence_ms !== want.silence_ms) begin
                $error("silence_ms: expected %0d, got %0d", want.silence_ms, got.silence_ms);
                fails++;
            end
            if (got.tied !== want.tied) begin
                $error("tied: expected %0d, got %0d", want.tied, got.tied);
                fails++;
            end
            if (got.error_code !== want.error_code) begin
                $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
                fails++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   steady;
    int   cycles = 0;

    note_scoreboard sb = new();

    mnd_char_if   char_ch();
    mnd_cfg_if    cfg_ch();
    mnd_result_if res_ch();

    music_note_decoder_unit uut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_char   (char_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk) begin
        t_note_result got;
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.tone_hz    = res_ch.tone_hz;
                got.sound_ms   = res_ch.sound_ms;
                got.silence_ms = res_ch.silence_ms;
                got.tied       = res_ch.tied;
                got.error_code = res_ch.error_code;
                sb.check_result(got);
            end
            if (cfg_ch.valid && cfg_ch.ready) sb.set_whole(cfg_ch.whole_note_ms);
            if (char_ch.valid && char_ch.ready)
                sb.accept_char(char_ch.note_char, char_ch.last_char);
        end
    end

    // result side: random stall before each item, none while steady
    initial begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
        end
    end

    // called and returns on a rising edge; valid stays high for a back-to-back item
    task automatic send_char(input logic [mnd_pkg::CHAR_W-1:0] c, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.note_char <= c;
        char_ch.last_char <= last;
        @(posedge clk);
        while (!char_ch.ready) @(posedge clk);
    endtask

    task automatic send_note(input t_note_text txt);
        foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
    endtask

    task automatic send_string(input string s);
        t_note_text txt;
        foreach (s[i]) txt.push_back(mnd_pkg::CHAR_W'(s[i]));
        send_note(txt);
    endtask

    // hold the sender off until every result is back, then let the block settle
    task automatic drain_block();
        char_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (RESULT_SLACK) @(posedge clk);
    endtask

    task automatic write_whole(input logic [mnd_pkg::WHOLE_W-1:0] v);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.whole_note_ms <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly well-formed notes with random content; some truncated, corrupted or noise
    function automatic void make_note(ref t_note_text txt);
        int kind;
        int f;
        int n;
        logic [mnd_pkg::CHAR_W-1:0] letter;
        txt.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            n = $urandom_range(1, 8);
            repeat (n) txt.push_back(mnd_pkg::CHAR_W'($urandom));
            return;
        end
        case ($urandom_range(0, 7))
            0: letter = mnd_pkg::CH_A;
            1: letter = mnd_pkg::CH_B;
            2: letter = mnd_pkg::CH_C;
            3: letter = mnd_pkg::CH_D;
            4: letter = mnd_pkg::CH_E;
            5: letter = mnd_pkg::CH_F;
            6: letter = mnd_pkg::CH_G;
            default: letter = mnd_pkg::CH_R;
        endcase
        txt.push_back(letter);
        if (letter != mnd_pkg::CH_R) begin
            case ($urandom_range(0, 2))
                1: txt.push_back(mnd_pkg::CH_SHARP);
                2: txt.push_back(mnd_pkg::CH_FLAT);
                default: ;
            endcase
            txt.push_back(mnd_pkg::CHAR_W'(mnd_pkg::CH_0 + $urandom_range(2, 8)));
        end
        txt.push_back(mnd_pkg::CH_SLASH);
        case ($urandom_range(0, 9))
            0: f = 0;
            1, 2, 3: f = 1 << $urandom_range(0, 6);
            default: f = $urandom_range(1, 99);
        endcase
        if (f >= 10 || $urandom_range(0, 2) == 0) begin
            txt.push_back(mnd_pkg::CHAR_W'(mnd_pkg::CH_0 + f / 10));
            txt.push_back(mnd_pkg::CHAR_W'(mnd_pkg::CH_0 + f % 10));
        end else begin
            txt.push_back(mnd_pkg::CHAR_W'(mnd_pkg::CH_0 + f));
        end
        if ($urandom_range(0, 1)) txt.push_back(mnd_pkg::CH_DOT);
        if ($urandom_range(0, 1)) txt.push_back(mnd_pkg::CH_TIE);
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) txt.push_back(mnd_pkg::CHAR_W'($urandom));
        end
        if (kind < 20) begin
            if ($urandom_range(0, 1)) begin
                n = $urandom_range(1, txt.size());
                while (txt.size() > n) void'(txt.pop_back());
            end else begin
                txt[$urandom_range(0, txt.size() - 1)] = mnd_pkg::CHAR_W'($urandom);
            end
        end
    endfunction

    initial begin : stimulus
        t_note_text                  txt;
        logic [mnd_pkg::WHOLE_W-1:0] phase_whole[6];
        int                          chars_sent;
        bit                          held_off;
        char_ch.valid        <= 1'b0;
        char_ch.note_char    <= '0;
        char_ch.last_char    <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.whole_note_ms <= '0;
        rst_n                <= 1'b0;
        steady = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed notes, first at the reset whole-note length, then at 0 and 240000 ms
        send_string("B#");
        send_string("Fb");
        send_string("X");
        send_string("G");
        send_string("A4");
        send_string("D4/");
        send_string("C2/0");
        send_string("R/16_Z");
        send_string("Eb3/08._");
        drain_block();
        write_whole('0);
        send_string("R/1");
        drain_block();
        write_whole(mnd_pkg::WHOLE_W'(240000));
        send_string("B8/1._");

        phase_whole = '{mnd_pkg::WHOLE_W'(1), mnd_pkg::WHOLE_W'(262143),
                        mnd_pkg::WHOLE_W'($urandom_range(1, 240000)),
                        mnd_pkg::WHOLE_W'($urandom_range(1, 240000)),
                        mnd_pkg::WHOLE_RESET, mnd_pkg::WHOLE_W'(240000)};
        foreach (phase_whole[p]) begin
            drain_block();
            write_whole(phase_whole[p]);
            steady = (p % 3 == 2);
            chars_sent = 0;
            held_off = 0;
            while (chars_sent < PHASE_CHARS) begin
                make_note(txt);
                send_note(txt);
                chars_sent += txt.size();
                if (!held_off && chars_sent >= PHASE_CHARS / 2) begin
                    drain_block();
                    held_off = 1;
                end
            end
        end

        drain_block();
        if (sb.fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
